### sv/bdq_pkg.sv
// Shared types and constants for the bounded deque with search and delete.
`default_nettype none

package bdq_pkg;

  localparam int unsigned DEF_CAPACITY = 16;
  localparam int unsigned DATA_W       = 32;
  localparam int unsigned CMD_W        = 3;
  localparam int unsigned STATUS_W     = 2;
  localparam int unsigned COUNT_W      = 5;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_PUSH_BACK  = 3'd1,
    CMD_POP_FRONT  = 3'd2,
    CMD_POP_BACK   = 3'd3,
    CMD_SEARCH     = 3'd4,
    CMD_DELETE     = 3'd5
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_NOTFOUND = 2'd2,
    ST_FULL     = 2'd3
  } status_e;

  // source of the result data word
  typedef enum logic [1:0] {
    DSEL_ZERO  = 2'd0,
    DSEL_KEY   = 2'd1,
    DSEL_RDATA = 2'd2
  } dsel_e;

  // controller -> datapath
  typedef struct packed {
    logic    ld_cmd;
    logic    start;
    logic    from_back;
    logic    scan_en;
    logic    push_front;
    logic    push_back;
    logic    shift_wr;
    logic    front_inc;
    logic    cnt_dec;
    logic    set_res;
    status_e res_status;
    dsel_e   res_data;
    logic    out_load;
  } ctl_t;

  // datapath -> controller
  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic             full;
    logic             empty;
    logic             hit;
    logic             last;
    logic             cmp_vld;
    logic             out_busy;
  } sts_t;

endpackage

`default_nettype wire

### sv/bdq_cmd_if.sv
// Command channel: valid/ready handshake carrying cmd and value.
`default_nettype none

interface bdq_cmd_if;
  import bdq_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [CMD_W-1:0]         cmd;
  logic signed [DATA_W-1:0] value;

  modport source (output valid, output cmd, output value, input ready);
  modport sink   (input valid, input cmd, input value, output ready);
endinterface

`default_nettype wire

### sv/bdq_rsp_if.sv
// Response channel: valid/ready handshake carrying status, data and count.
`default_nettype none

interface bdq_rsp_if;
  import bdq_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [STATUS_W-1:0]      status;
  logic signed [DATA_W-1:0] data;
  logic [COUNT_W-1:0]       count;

  modport source (output valid, output status, output data, output count, input ready);
  modport sink   (input valid, input status, input data, input count, output ready);
endinterface

`default_nettype wire

### sv/bdq_ctrl.sv
// Controller state machine: sequences push, pop, scan and gap-closing shift.
`default_nettype none

module bdq_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire bdq_pkg::sts_t sts_i,
  output bdq_pkg::ctl_t      ctl_o
);
  import bdq_pkg::*;

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_DISPATCH = 3'd1;
  localparam logic [2:0] S_POP_RD   = 3'd2;
  localparam logic [2:0] S_POP_DONE = 3'd3;
  localparam logic [2:0] S_SCAN     = 3'd4;
  localparam logic [2:0] S_SHIFT    = 3'd5;
  localparam logic [2:0] S_FINISH   = 3'd6;

  logic [2:0] state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    ctl_o      = '0;
    in_ready_o = 1'b0;

    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          ctl_o.ld_cmd = 1'b1;
          state_d      = S_DISPATCH;
        end
      end

      S_DISPATCH: begin
        state_d = S_FINISH;
        case (sts_i.cmd)
          CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
            ctl_o.set_res  = 1'b1;
            ctl_o.res_data = DSEL_ZERO;
            if (sts_i.full) begin
              ctl_o.res_status = ST_FULL;
            end else begin
              ctl_o.res_status = ST_OK;
              ctl_o.push_front = (sts_i.cmd == CMD_PUSH_FRONT);
              ctl_o.push_back  = (sts_i.cmd == CMD_PUSH_BACK);
            end
          end
          CMD_POP_FRONT, CMD_POP_BACK: begin
            if (sts_i.empty) begin
              ctl_o.set_res    = 1'b1;
              ctl_o.res_status = ST_EMPTY;
              ctl_o.res_data   = DSEL_ZERO;
            end else begin
              ctl_o.start     = 1'b1;
              ctl_o.from_back = (sts_i.cmd == CMD_POP_BACK);
              state_d         = S_POP_RD;
            end
          end
          CMD_SEARCH, CMD_DELETE: begin
            if (sts_i.empty) begin
              ctl_o.set_res    = 1'b1;
              ctl_o.res_status = (sts_i.cmd == CMD_SEARCH) ? ST_NOTFOUND : ST_EMPTY;
              ctl_o.res_data   = DSEL_ZERO;
            end else begin
              ctl_o.start = 1'b1;
              state_d     = S_SCAN;
            end
          end
          default: begin
            ctl_o.set_res    = 1'b1;
            ctl_o.res_status = ST_OK;
            ctl_o.res_data   = DSEL_ZERO;
          end
        endcase
      end

      S_POP_RD: begin
        state_d = S_POP_DONE;
      end

      S_POP_DONE: begin
        ctl_o.set_res    = 1'b1;
        ctl_o.res_status = ST_OK;
        ctl_o.res_data   = DSEL_RDATA;
        ctl_o.cnt_dec    = 1'b1;
        ctl_o.front_inc  = (sts_i.cmd == CMD_POP_FRONT);
        state_d          = S_FINISH;
      end

      S_SCAN: begin
        ctl_o.scan_en = 1'b1;
        if (sts_i.hit) begin
          ctl_o.set_res    = 1'b1;
          ctl_o.res_status = ST_OK;
          ctl_o.res_data   = DSEL_KEY;
          state_d          = (sts_i.cmd == CMD_DELETE) ? S_SHIFT : S_FINISH;
        end else if (sts_i.last) begin
          ctl_o.set_res    = 1'b1;
          ctl_o.res_status = ST_NOTFOUND;
          ctl_o.res_data   = DSEL_ZERO;
          state_d          = S_FINISH;
        end
      end

      // entry i+1 read in the cycle before is written back to entry i
      S_SHIFT: begin
        ctl_o.scan_en = 1'b1;
        if (sts_i.cmp_vld) begin
          ctl_o.shift_wr = 1'b1;
        end else begin
          ctl_o.cnt_dec = 1'b1;
          state_d       = S_FINISH;
        end
      end

      S_FINISH: begin
        if (!sts_i.out_busy) begin
          ctl_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

### sv/bdq_datapath.sv
// Datapath: ring store, front/count registers, scan pipeline and result register.
`default_nettype none

module bdq_datapath #(
  parameter int unsigned CAPACITY = bdq_pkg::DEF_CAPACITY
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic [bdq_pkg::CMD_W-1:0]        cmd_i,
  input  wire logic signed [bdq_pkg::DATA_W-1:0] value_i,
  input  wire bdq_pkg::ctl_t                    ctl_i,
  output bdq_pkg::sts_t                         sts_o,
  input  wire logic                             out_ready_i,
  output logic                                  out_valid_o,
  output logic [bdq_pkg::STATUS_W-1:0]          status_o,
  output logic signed [bdq_pkg::DATA_W-1:0]     data_o,
  output logic [bdq_pkg::COUNT_W-1:0]           count_o
);
  import bdq_pkg::*;

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam logic [CW:0]   CapExt  = (CW+1)'(CAPACITY);
  localparam logic [CW-1:0] CapCnt  = CW'(CAPACITY);
  localparam logic [AW-1:0] LastIdx = AW'(CAPACITY - 1);

  // ring position of logical entry pos; base + pos stays below twice the capacity
  function automatic logic [AW-1:0] slot(input logic [AW-1:0] base,
                                         input logic [CW-1:0] pos);
    logic [CW:0] sum;
    sum = (CW+1)'(base) + (CW+1)'(pos);
    if (sum >= CapExt) begin
      sum = sum - CapExt;
    end
    return sum[AW-1:0];
  endfunction

  logic [DATA_W-1:0]   mem_q [CAPACITY];
  logic [DATA_W-1:0]   rdata_q;
  logic [CMD_W-1:0]    cmd_q;
  logic [DATA_W-1:0]   key_q;
  logic [AW-1:0]       front_q, front_d;
  logic [CW-1:0]       count_q, count_d;
  logic [CW-1:0]       rd_pos_q, rd_pos_d;
  logic [CW-1:0]       cmp_pos_q;
  logic                cmp_vld_q, cmp_vld_d;
  logic [STATUS_W-1:0] res_status_q;
  logic [DATA_W-1:0]   res_data_q, res_data_d;
  logic                out_valid_q;
  logic [STATUS_W-1:0] out_status_q;
  logic [DATA_W-1:0]   out_data_q;
  logic [COUNT_W-1:0]  out_count_q;

  logic [AW-1:0]       front_m1;
  logic [AW-1:0]       rd_addr;
  logic                wr_en;
  logic [AW-1:0]       wr_addr;
  logic [DATA_W-1:0]   wr_data;
  logic                rd_more;
  logic [CW+COUNT_W-1:0] cnt_ext;

  assign front_m1 = (front_q == '0) ? LastIdx : front_q - AW'(1);
  assign rd_addr  = slot(front_q, rd_pos_q);
  assign rd_more  = (rd_pos_q < count_q);
  assign cnt_ext  = {{COUNT_W{1'b0}}, count_q};

  // write port
  always_comb begin
    wr_en   = ctl_i.push_front | ctl_i.push_back | ctl_i.shift_wr;
    wr_addr = front_m1;
    wr_data = key_q;
    if (ctl_i.push_back) begin
      wr_addr = slot(front_q, count_q);
    end else if (ctl_i.shift_wr) begin
      wr_addr = slot(front_q, cmp_pos_q - CW'(1));
      wr_data = rdata_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    rdata_q <= mem_q[rd_addr];
  end

  always_comb begin
    front_d = front_q;
    if (ctl_i.push_front) begin
      front_d = front_m1;
    end else if (ctl_i.front_inc) begin
      front_d = (front_q == LastIdx) ? '0 : front_q + AW'(1);
    end
  end

  always_comb begin
    count_d = count_q;
    if (ctl_i.push_front || ctl_i.push_back) begin
      count_d = count_q + CW'(1);
    end else if (ctl_i.cnt_dec) begin
      count_d = count_q - CW'(1);
    end
  end

  always_comb begin
    rd_pos_d  = rd_pos_q;
    cmp_vld_d = cmp_vld_q;
    if (ctl_i.start) begin
      rd_pos_d  = ctl_i.from_back ? count_q - CW'(1) : '0;
      cmp_vld_d = 1'b0;
    end else if (ctl_i.scan_en) begin
      cmp_vld_d = rd_more;
      if (rd_more) begin
        rd_pos_d = rd_pos_q + CW'(1);
      end
    end
  end

  always_comb begin
    case (ctl_i.res_data)
      DSEL_ZERO:  res_data_d = '0;
      DSEL_KEY:   res_data_d = key_q;
      DSEL_RDATA: res_data_d = rdata_q;
      default:    res_data_d = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q     <= '0;
      count_q     <= '0;
      cmp_vld_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      front_q   <= front_d;
      count_q   <= count_d;
      cmp_vld_q <= cmp_vld_d;
      if (ctl_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rd_pos_q <= rd_pos_d;
    if (ctl_i.scan_en) begin
      cmp_pos_q <= rd_pos_q;
    end
    if (ctl_i.ld_cmd) begin
      cmd_q <= cmd_i;
      key_q <= value_i;
    end
    if (ctl_i.set_res) begin
      res_status_q <= ctl_i.res_status;
      res_data_q   <= res_data_d;
    end
    if (ctl_i.out_load) begin
      out_status_q <= res_status_q;
      out_data_q   <= res_data_q;
      out_count_q  <= cnt_ext[COUNT_W-1:0];
    end
  end

  assign sts_o.cmd      = cmd_q;
  assign sts_o.full     = (count_q == CapCnt);
  assign sts_o.empty    = (count_q == '0);
  assign sts_o.hit      = cmp_vld_q && (rdata_q == key_q);
  assign sts_o.last     = cmp_vld_q && (cmp_pos_q == count_q - CW'(1));
  assign sts_o.cmp_vld  = cmp_vld_q;
  assign sts_o.out_busy = out_valid_q && !out_ready_i;

  assign out_valid_o = out_valid_q;
  assign status_o    = out_status_q;
  assign data_o      = out_data_q;
  assign count_o     = out_count_q;

endmodule

`default_nettype wire

### sv/bounded_deque_with_search_delete.sv
// Top level: bounded deque with search and delete-by-value over a ring store.
//
//   channel | dir | beat fields              | handshake
//   cmd_i   | in  | cmd[2:0], value[31:0]    | valid/ready
//   rsp_o   | out | status, data, count[4:0] | valid/ready
//
// One command in flight at a time; every command gives one response beat.
// The ring store reads one entry per cycle, which sets the pace of the scan
// and of the gap-closing shift. Reset clears the controller state, front,
// count, compare-valid and output-valid registers only; store entries are
// undefined until pushed. A response waiting on rsp_o does not block the
// next command beat; the following response waits for the output register
// to free.
`default_nettype none

module bounded_deque_with_search_delete #(
  parameter int unsigned CAPACITY = bdq_pkg::DEF_CAPACITY
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  bdq_cmd_if.sink   cmd_i,
  bdq_rsp_if.source rsp_o
);
  import bdq_pkg::*;

  ctl_t ctl;
  sts_t sts;
  logic in_ready;

  bdq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (cmd_i.valid),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .ctl_o      (ctl)
  );

  bdq_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd_i.cmd),
    .value_i     (cmd_i.value),
    .ctl_i       (ctl),
    .sts_o       (sts),
    .out_ready_i (rsp_o.ready),
    .out_valid_o (rsp_o.valid),
    .status_o    (rsp_o.status),
    .data_o      (rsp_o.data),
    .count_o     (rsp_o.count)
  );

  assign cmd_i.ready = in_ready;

endmodule

`default_nettype wire

### sim/bounded_deque_with_search_delete_tb.sv
// Testbench for the bounded deque: queue-based predictor, random traffic, scoreboard.
`timescale 1ns / 100ps

module bounded_deque_with_search_delete_tb;
  import bdq_pkg::*;

  localparam int unsigned CAP          = DEF_CAPACITY;
  localparam int unsigned CLK_PERIOD   = 10;
  localparam int unsigned RESET_CYCLES = 5;
  localparam int unsigned HOLD_CYCLES  = 80;
  localparam int unsigned STALL_LIMIT  = 2000;
  // worst case: delete walks the list, then shifts the tail
  localparam int unsigned SETTLE_CYCLES = 2 * CAP + 8;

  localparam logic [CMD_W-1:0] CMD_RSVD6 = 3'd6;
  localparam logic [CMD_W-1:0] CMD_RSVD7 = 3'd7;

  localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;

  typedef struct {
    status_e                  status;
    logic signed [DATA_W-1:0] data;
    logic [COUNT_W-1:0]       count;
  } deque_rsp_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  bdq_cmd_if cmd_if ();
  bdq_rsp_if rsp_if ();

  bounded_deque_with_search_delete #(
    .CAPACITY(CAP)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cmd_i (cmd_if),
    .rsp_o (rsp_if)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  logic signed [DATA_W-1:0] deque_q[$];     // predicted list contents, front first
  deque_rsp_t               due_rsp_q[$];   // responses still owed by the block
  int unsigned              idle_pct      = 35;
  int unsigned              rsp_hold_left = 0;
  int unsigned              err_count     = 0;
  int unsigned              rsp_beats     = 0;
  int unsigned              stall_cycles  = 0;

  task automatic report_mismatch(input string msg);
    $display("mismatch at rsp beat %0d: %s", rsp_beats, msg);
    err_count++;
  endtask

  // Apply one accepted command to the predicted list and queue its response.
  function automatic void deque_apply(input logic [CMD_W-1:0] op,
                                      input logic signed [DATA_W-1:0] val);
    deque_rsp_t r;
    int         hit;
    r.status = ST_OK;
    r.data   = '0;
    hit      = -1;
    case (op)
      CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
        if (deque_q.size() >= CAP) begin
          r.status = ST_FULL;
        end else if (op == CMD_PUSH_FRONT) begin
          deque_q.push_front(val);
        end else begin
          deque_q.push_back(val);
        end
      end
      CMD_POP_FRONT, CMD_POP_BACK: begin
        if (deque_q.size() == 0) begin
          r.status = ST_EMPTY;
        end else if (op == CMD_POP_FRONT) begin
          r.data = deque_q.pop_front();
        end else begin
          r.data = deque_q.pop_back();
        end
      end
      CMD_SEARCH, CMD_DELETE: begin
        // delete on an empty list says empty, search says not found
        if (op == CMD_DELETE && deque_q.size() == 0) begin
          r.status = ST_EMPTY;
        end else begin
          for (int i = 0; i < deque_q.size(); i++) begin
            if (hit < 0 && deque_q[i] == val) hit = i;
          end
          if (hit < 0) begin
            r.status = ST_NOTFOUND;
          end else begin
            r.data = val;
            if (op == CMD_DELETE) deque_q.delete(hit);
          end
        end
      end
      default: ;
    endcase
    r.count = COUNT_W'(deque_q.size());
    due_rsp_q.push_back(r);
  endfunction

  // Weighted random opcode; pushes and pops pick an end at random.
  function automatic logic [CMD_W-1:0] pick_op(input int unsigned w_push, input int unsigned w_pop,
                                               input int unsigned w_find, input int unsigned w_del,
                                               input int unsigned w_rsvd);
    int unsigned r;
    r = $urandom_range(w_push + w_pop + w_find + w_del + w_rsvd - 1);
    if (r < w_push) return $urandom_range(1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT;
    r -= w_push;
    if (r < w_pop) return $urandom_range(1) ? CMD_POP_BACK : CMD_POP_FRONT;
    r -= w_pop;
    if (r < w_find) return CMD_SEARCH;
    r -= w_find;
    if (r < w_del) return CMD_DELETE;
    return $urandom_range(1) ? CMD_RSVD7 : CMD_RSVD6;
  endfunction

  // Values biased toward current contents and a small pool, so keys hit and repeat.
  function automatic logic signed [DATA_W-1:0] rand_value();
    int unsigned              r;
    logic signed [DATA_W-1:0] v;
    r = $urandom_range(99);
    if (r < 40 && deque_q.size() != 0) return deque_q[$urandom_range(deque_q.size() - 1)];
    if (r < 70) begin
      v = $urandom_range(7);
      return v - 4;
    end
    if (r < 80) begin
      case ($urandom_range(3))
        0:       v = VAL_MIN;
        1:       v = VAL_MAX;
        2:       v = '0;
        default: v = '1;
      endcase
      return v;
    end
    v = $urandom;
    return v;
  endfunction

  // Entered and left at a falling edge; valid stays high after a beat so the
  // next call either keeps it up or drops it for an idle gap.
  task automatic send_cmd(input logic [CMD_W-1:0] op, input logic signed [DATA_W-1:0] val);
    while ($urandom_range(99) < idle_pct) begin
      cmd_if.valid <= 1'b0;
      cmd_if.cmd   <= CMD_W'($urandom_range(7));
      cmd_if.value <= $urandom;
      @(negedge clk_i);
    end
    cmd_if.valid <= 1'b1;
    cmd_if.cmd   <= op;
    cmd_if.value <= val;
    do @(posedge clk_i); while (!cmd_if.ready);
    deque_apply(op, val);
    @(negedge clk_i);
  endtask

  task automatic drain_results();
    cmd_if.valid <= 1'b0;
    while (due_rsp_q.size() != 0) @(negedge clk_i);
  endtask

  task automatic test_empty_cases();
    send_cmd(CMD_POP_FRONT, rand_value());
    send_cmd(CMD_POP_BACK, rand_value());
    send_cmd(CMD_DELETE, VAL_MAX);
    send_cmd(CMD_SEARCH, VAL_MIN);
    send_cmd(CMD_RSVD6, $urandom);
    send_cmd(CMD_RSVD7, $urandom);
  endtask

  task automatic test_edge_values();
    send_cmd(CMD_PUSH_FRONT, VAL_MIN);
    send_cmd(CMD_PUSH_BACK, VAL_MAX);
    send_cmd(CMD_PUSH_FRONT, '0);
    send_cmd(CMD_PUSH_BACK, '1);
    send_cmd(CMD_SEARCH, VAL_MAX);
    send_cmd(CMD_SEARCH, VAL_MIN);
    send_cmd(CMD_SEARCH, 32'sd1);
    send_cmd(CMD_RSVD7, VAL_MAX);
    send_cmd(CMD_DELETE, VAL_MIN);     // gap in the middle
    send_cmd(CMD_DELETE, VAL_MIN);     // already gone
    send_cmd(CMD_POP_BACK, '0);
    send_cmd(CMD_POP_FRONT, '0);
    send_cmd(CMD_POP_FRONT, '0);
    send_cmd(CMD_SEARCH, VAL_MAX);     // empty again
  endtask

  task automatic test_random_mix(input int unsigned n);
    repeat (n) send_cmd(pick_op(35, 25, 18, 17, 5), rand_value());
  endtask

  // Fill past full, probe, then empty past empty.
  task automatic test_fill_drain(input int unsigned rounds);
    repeat (rounds) begin
      while (deque_q.size() < CAP) send_cmd(pick_op(1, 0, 0, 0, 0), rand_value());
      repeat ($urandom_range(3, 1)) send_cmd(pick_op(1, 0, 0, 0, 0), $urandom);
      repeat (4) send_cmd(pick_op(0, 0, 1, 1, 0), rand_value());
      while (deque_q.size() != 0) send_cmd(pick_op(0, 6, 1, 2, 0), rand_value());
      repeat ($urandom_range(2, 1)) send_cmd(pick_op(0, 3, 1, 1, 0), rand_value());
    end
  endtask

  task automatic test_search_delete(input int unsigned n);
    repeat (n) send_cmd(pick_op(30, 10, 30, 30, 0), rand_value());
  endtask

  // Response side stalls while commands keep coming; input must back up.
  task automatic test_backpressure();
    rsp_hold_left = HOLD_CYCLES;
    repeat (40) send_cmd(pick_op(40, 20, 20, 15, 5), rand_value());
  endtask

  task automatic test_back_to_back(input int unsigned n);
    idle_pct = 0;
    repeat (n) send_cmd(pick_op(35, 25, 18, 17, 5), rand_value());
    drain_results();
    idle_pct = 35;
  endtask

  initial begin : stimulus
    cmd_if.valid <= 1'b0;
    cmd_if.cmd   <= CMD_PUSH_FRONT;
    cmd_if.value <= '0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_empty_cases();
    test_edge_values();
    drain_results();
    test_random_mix(400);
    drain_results();
    test_fill_drain(5);
    drain_results();
    test_search_delete(200);
    drain_results();
    test_backpressure();
    drain_results();
    test_back_to_back(80);

    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (err_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin : rsp_sink
    rsp_if.ready <= 1'b0;
    forever begin
      @(negedge clk_i);
      if (rsp_hold_left > 0) begin
        rsp_if.ready <= 1'b0;
        rsp_hold_left--;
      end else begin
        rsp_if.ready <= ($urandom_range(99) >= idle_pct);
      end
    end
  end

  task automatic check_rsp();
    deque_rsp_t want;
    rsp_beats++;
    if (due_rsp_q.size() == 0) begin
      report_mismatch("response beat with nothing outstanding");
    end else begin
      want = due_rsp_q.pop_front();
      if (rsp_if.status !== want.status)
        report_mismatch($sformatf("st got %0d want %0d", rsp_if.status, want.status));
      if (rsp_if.data !== want.data)
        report_mismatch($sformatf("data got %0d want %0d", rsp_if.data, want.data));
      if (rsp_if.count !== want.count)
        report_mismatch($sformatf("count got %0d want %0d", rsp_if.count, want.count));
    end
  endtask

  always @(posedge clk_i) begin : rsp_monitor
    if (rst_ni && rsp_if.valid && rsp_if.ready) check_rsp();
  end

  always @(posedge clk_i) begin : watchdog
    if (!rst_ni || (cmd_if.valid && cmd_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

endmodule
